### rtl/cbm_pkg.sv
package cbm_pkg;

  // Item kind carried on the input tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // Result kind carried on the output tuser
  typedef enum logic [1:0] {
    EV_PATTERN = 2'd0,
    EV_PROGRAM = 2'd1,
    EV_MIRROR  = 2'd2,
    EV_IRQ     = 2'd3
  } event_kind_t;

  // Bus widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  // Register port decode
  localparam logic [15:0] ADDR_MASK    = 16'hF003;
  localparam logic [15:0] PORT_CMD     = 16'h8000;
  localparam logic [15:0] PORT_DATA    = 16'h8001;
  localparam logic [15:0] PORT_MIRROR  = 16'hA000;
  localparam logic [15:0] PORT_LATCH   = 16'hC000;
  localparam logic [15:0] PORT_RELOAD  = 16'hC001;
  localparam logic [15:0] PORT_IRQ_OFF = 16'hE000;
  localparam logic [15:0] PORT_IRQ_ON  = 16'hE001;

  // Command byte fields
  localparam logic [7:0] CMD_INDEX_MASK = 8'h0F;
  localparam logic [7:0] CMD_PRG_MODE   = 8'h40;
  localparam logic [7:0] CMD_CHR_INV    = 8'h80;

  // Bank commands
  localparam logic [3:0] CMD_CHR_2K_0 = 4'h0;
  localparam logic [3:0] CMD_CHR_2K_1 = 4'h1;
  localparam logic [3:0] CMD_CHR_1K_2 = 4'h2;
  localparam logic [3:0] CMD_CHR_1K_3 = 4'h3;
  localparam logic [3:0] CMD_CHR_1K_4 = 4'h4;
  localparam logic [3:0] CMD_CHR_1K_5 = 4'h5;
  localparam logic [3:0] CMD_PRG_0    = 4'h6;
  localparam logic [3:0] CMD_PRG_1    = 4'h7;
  localparam logic [3:0] CMD_CHR_1K_8 = 4'h8;
  localparam logic [3:0] CMD_CHR_1K_9 = 4'h9;
  localparam logic [3:0] CMD_PRG_2    = 4'hF;

  // Window sizes in KB
  localparam logic [3:0] KB_1 = 4'd1;
  localparam logic [3:0] KB_2 = 4'd2;
  localparam logic [3:0] KB_8 = 4'd8;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  typedef struct packed {
    logic [3:0] command_index;
    logic       program_mode;
    logic       pattern_invert;
    logic [7:0] irq_count;
    logic [7:0] irq_reload;
    logic       irq_on;
  } cbm_state_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [8:0]  line_number;
    logic        rendering_on;
  } cbm_item_t;

  typedef struct packed {
    logic        valid;
    event_kind_t event_kind;
    logic [15:0] window_address;
    logic [3:0]  window_kilobytes;
    logic [7:0]  bank_number;
    logic        mirror_horizontal;
  } cbm_result_t;

endpackage

### rtl/cartridge_bank_mapper_with_scanline_irq.sv
// Bank mapper with scanline interrupt counter. Input items are CPU writes
// (in_tuser = 0) or horizontal blank ticks (in_tuser = 1); each yields zero
// or one result item: a pattern or program bank assignment, a mirroring
// change, or an interrupt request. The block takes one item per clock while
// out_tready stays high. An item waits in the input register, where the
// mapper state is read and updated, and its result then sits in the output
// register until taken; both registers let items stream back to back as
// long as out_tready stays high.
module cartridge_bank_mapper_with_scanline_irq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] cpu_address, [23:16] write_data, [32:24] line_number,
  // [33] rendering_on, [39:34] zero
  input  logic [cbm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] op
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] window_address, [19:16] window_kilobytes, [27:20] bank_number,
  // [28] mirror_horizontal, [31:29] zero
  output logic [cbm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] event_kind
  output logic [1:0]                         out_tuser
);
  import cbm_pkg::*;

  logic        item_valid_r;
  cbm_item_t   item_r;
  logic        item_advance;
  cbm_state_t  state_r;
  cbm_state_t  state_nxt;
  cbm_result_t result;
  logic        out_valid_r;
  cbm_result_t out_r;

  // Input register moves on when the output register is free or drains
  assign item_advance = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready    = !item_valid_r || item_advance;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op           <= op_t'(in_tuser);
      item_r.cpu_address  <= in_tdata[15:0];
      item_r.write_data   <= in_tdata[23:16];
      item_r.line_number  <= in_tdata[32:24];
      item_r.rendering_on <= in_tdata[33];
    end
  end

  cbm_core u_core (
    .state     (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Update mapper state as the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (item_advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_advance) begin
      out_valid_r <= result.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_advance) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.event_kind;
  assign out_tdata  = {3'b000, out_r.mirror_horizontal, out_r.bank_number,
                       out_r.window_kilobytes, out_r.window_address};

endmodule

### rtl/cbm_core.sv
module cbm_core (
  input  cbm_pkg::cbm_state_t  state,
  input  cbm_pkg::cbm_item_t   item,
  output cbm_pkg::cbm_state_t  state_nxt,
  output cbm_pkg::cbm_result_t result
);
  import cbm_pkg::*;

  logic [15:0] masked_addr;
  logic [7:0]  count_dec;
  logic        visible_count;

  assign masked_addr   = item.cpu_address & ADDR_MASK;
  assign count_dec     = state.irq_count - 8'd1;
  assign visible_count = state.irq_on && (item.line_number <= LAST_VISIBLE_LINE) &&
                         item.rendering_on;

  // Decode one item into a state update and at most one result
  always_comb begin
    state_nxt = state;
    result    = '0;
    if (item.op == OP_TICK) begin
      // Count visible lines; reload and raise an interrupt at zero
      if (visible_count) begin
        if (count_dec == 8'd0) begin
          state_nxt.irq_count = state.irq_reload;
          result.valid        = 1'b1;
          result.event_kind   = EV_IRQ;
        end else begin
          state_nxt.irq_count = count_dec;
        end
      end
    end else begin
      unique case (masked_addr)
        PORT_CMD: begin
          state_nxt.command_index  = item.write_data[3:0] & CMD_INDEX_MASK[3:0];
          state_nxt.program_mode   = |(item.write_data & CMD_PRG_MODE);
          state_nxt.pattern_invert = |(item.write_data & CMD_CHR_INV);
        end
        PORT_DATA: begin
          result.bank_number = item.write_data;
          result.valid       = 1'b1;
          unique case (state.command_index)
            CMD_CHR_2K_0: begin
              result.event_kind       = EV_PATTERN;
              result.window_address   = state.pattern_invert ? 16'h1000 : 16'h0000;
              result.window_kilobytes = KB_2;
              result.bank_number      = {1'b0, item.write_data[7:1]};
            end
            CMD_CHR_2K_1: begin
              result.event_kind       = EV_PATTERN;
              result.window_address   = state.pattern_invert ? 16'h1800 : 16'h0800;
              result.window_kilobytes = KB_2;
              result.bank_number      = {1'b0, item.write_data[7:1]};
            end
            CMD_CHR_1K_2: begin
              result.event_kind       = EV_PATTERN;
              result.window_address   = state.pattern_invert ? 16'h0000 : 16'h1000;
              result.window_kilobytes = KB_1;
            end
            CMD_CHR_1K_3: begin
              result.event_kind       = EV_PATTERN;
              result.window_address   = state.pattern_invert ? 16'h0400 : 16'h1400;
              result.window_kilobytes = KB_1;
            end
            CMD_CHR_1K_4: begin
              result.event_kind       = EV_PATTERN;
              result.window_address   = state.pattern_invert ? 16'h0800 : 16'h1800;
              result.window_kilobytes = KB_1;
            end
            CMD_CHR_1K_5: begin
              result.event_kind       = EV_PATTERN;
              result.window_address   = state.pattern_invert ? 16'h0C00 : 16'h1C00;
              result.window_kilobytes = KB_1;
            end
            CMD_PRG_0: begin
              result.event_kind       = EV_PROGRAM;
              result.window_address   = state.program_mode ? 16'hA000 : 16'h8000;
              result.window_kilobytes = KB_8;
            end
            CMD_PRG_1: begin
              result.event_kind       = EV_PROGRAM;
              result.window_address   = state.program_mode ? 16'hC000 : 16'hA000;
              result.window_kilobytes = KB_8;
            end
            CMD_CHR_1K_8: begin
              result.event_kind       = EV_PATTERN;
              result.window_address   = 16'h0400;
              result.window_kilobytes = KB_1;
            end
            CMD_CHR_1K_9: begin
              result.event_kind       = EV_PATTERN;
              result.window_address   = 16'h0C00;
              result.window_kilobytes = KB_1;
            end
            CMD_PRG_2: begin
              result.event_kind       = EV_PROGRAM;
              result.window_address   = state.program_mode ? 16'h8000 : 16'hC000;
              result.window_kilobytes = KB_8;
            end
            default: begin
              // unused commands: drop the item
              result = '0;
            end
          endcase
        end
        PORT_MIRROR: begin
          result.valid             = 1'b1;
          result.event_kind        = EV_MIRROR;
          result.mirror_horizontal = item.write_data[0];
        end
        PORT_LATCH: begin
          state_nxt.irq_reload = item.write_data;
          state_nxt.irq_count  = item.write_data;
        end
        PORT_RELOAD: begin
          state_nxt.irq_count = state.irq_reload;
        end
        PORT_IRQ_OFF: begin
          state_nxt.irq_on    = 1'b0;
          state_nxt.irq_count = state.irq_reload;
        end
        PORT_IRQ_ON: begin
          state_nxt.irq_on    = 1'b1;
          state_nxt.irq_count = state.irq_reload;
        end
        default: begin
          // undecoded address: no change
          state_nxt = state;
        end
      endcase
    end
  end

endmodule

### tb/cartridge_bank_mapper_with_scanline_irq_checker.sv
module cartridge_bank_mapper_with_scanline_irq_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [15:0] cpu_address, [23:16] write_data, [32:24] line_number,
  // [33] rendering_on, [39:34] zero
  input  logic [cbm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] op
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] window_address, [19:16] window_kilobytes, [27:20] bank_number,
  // [28] mirror_horizontal, [31:29] zero
  input  logic [cbm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] event_kind
  input  logic [1:0]                      out_tuser,
  output int unsigned                     fail_count,
  output int unsigned                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  // Shadow copy of the mapper registers
  logic [3:0] cmd_sel;
  logic       prg_swap;
  logic       chr_flip;
  logic [7:0] line_counter;
  logic [7:0] counter_latch;
  logic       irq_armed;

  cbm_result_t expected_events[$];
  cbm_item_t   seen_item;
  cbm_result_t seen_event;
  cbm_result_t oldest_event;

  function automatic cbm_result_t window_event(event_kind_t kind, logic [15:0] addr,
                                               logic [3:0] kb, logic [7:0] bank);
    cbm_result_t ev;
    ev = '0;
    ev.valid            = 1'b1;
    ev.event_kind       = kind;
    ev.window_address   = addr;
    ev.window_kilobytes = kb;
    ev.bank_number      = bank;
    return ev;
  endfunction

  // Apply one item to the shadow registers and work out the event it causes
  task automatic predict_mapper_event(input cbm_item_t item, output cbm_result_t ev);
    logic [7:0] d;
    d  = item.write_data;
    ev = '0;
    if (item.op == OP_TICK) begin
      // Count only visible lines while rendering and armed; fire on zero
      if (irq_armed && item.line_number <= LAST_VISIBLE_LINE && item.rendering_on) begin
        line_counter = line_counter - 8'd1;
        if (line_counter == 8'd0) begin
          line_counter  = counter_latch;
          ev.valid      = 1'b1;
          ev.event_kind = EV_IRQ;
        end
      end
    end else begin
      case (item.cpu_address & ADDR_MASK)
        PORT_CMD: begin
          cmd_sel  = d[3:0] & CMD_INDEX_MASK[3:0];
          prg_swap = |(d & CMD_PRG_MODE);
          chr_flip = |(d & CMD_CHR_INV);
        end
        PORT_DATA: begin
          case (cmd_sel)
            CMD_CHR_2K_0: ev = window_event(EV_PATTERN, chr_flip ? 16'h1000 : 16'h0000,
                                            KB_2, {1'b0, d[7:1]});
            CMD_CHR_2K_1: ev = window_event(EV_PATTERN, chr_flip ? 16'h1800 : 16'h0800,
                                            KB_2, {1'b0, d[7:1]});
            CMD_CHR_1K_2: ev = window_event(EV_PATTERN, chr_flip ? 16'h0000 : 16'h1000,
                                            KB_1, d);
            CMD_CHR_1K_3: ev = window_event(EV_PATTERN, chr_flip ? 16'h0400 : 16'h1400,
                                            KB_1, d);
            CMD_CHR_1K_4: ev = window_event(EV_PATTERN, chr_flip ? 16'h0800 : 16'h1800,
                                            KB_1, d);
            CMD_CHR_1K_5: ev = window_event(EV_PATTERN, chr_flip ? 16'h0C00 : 16'h1C00,
                                            KB_1, d);
            CMD_PRG_0:    ev = window_event(EV_PROGRAM, prg_swap ? 16'hA000 : 16'h8000,
                                            KB_8, d);
            CMD_PRG_1:    ev = window_event(EV_PROGRAM, prg_swap ? 16'hC000 : 16'hA000,
                                            KB_8, d);
            CMD_CHR_1K_8: ev = window_event(EV_PATTERN, 16'h0400, KB_1, d);
            CMD_CHR_1K_9: ev = window_event(EV_PATTERN, 16'h0C00, KB_1, d);
            CMD_PRG_2:    ev = window_event(EV_PROGRAM, prg_swap ? 16'h8000 : 16'hC000,
                                            KB_8, d);
            default: ;
          endcase
        end
        PORT_MIRROR: begin
          ev.valid             = 1'b1;
          ev.event_kind        = EV_MIRROR;
          ev.mirror_horizontal = d[0];
        end
        PORT_LATCH: begin
          counter_latch = d;
          line_counter  = d;
        end
        PORT_RELOAD: line_counter = counter_latch;
        PORT_IRQ_OFF: begin
          irq_armed    = 1'b0;
          line_counter = counter_latch;
        end
        PORT_IRQ_ON: begin
          irq_armed    = 1'b1;
          line_counter = counter_latch;
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Match taken results against the oldest event, then record the new item
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_sel       = '0;
      prg_swap      = 1'b0;
      chr_flip      = 1'b0;
      line_counter  = '0;
      counter_latch = '0;
      irq_armed     = 1'b0;
      expected_events.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result item, expected none, actual kind %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          oldest_event = expected_events.pop_front();
          check_field("event_kind", 16'(oldest_event.event_kind), 16'(out_tuser));
          check_field("window_address", oldest_event.window_address, out_tdata[15:0]);
          check_field("window_kilobytes", 16'(oldest_event.window_kilobytes),
                      16'(out_tdata[19:16]));
          check_field("bank_number", 16'(oldest_event.bank_number), 16'(out_tdata[27:20]));
          check_field("mirror_horizontal", 16'(oldest_event.mirror_horizontal),
                      16'(out_tdata[28]));
          check_field("tdata padding", 16'd0, 16'(out_tdata[31:29]));
        end
      end
      if (in_tvalid && in_tready) begin
        seen_item.op           = op_t'(in_tuser);
        seen_item.cpu_address  = in_tdata[15:0];
        seen_item.write_data   = in_tdata[23:16];
        seen_item.line_number  = in_tdata[32:24];
        seen_item.rendering_on = in_tdata[33];
        predict_mapper_event(seen_item, seen_event);
        if (seen_event.valid) expected_events.push_back(seen_event);
      end
    end
    pending = expected_events.size();
  end

endmodule

### tb/cartridge_bank_mapper_with_scanline_irq_test.sv
module cartridge_bank_mapper_with_scanline_irq_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  localparam logic [3:0] UNUSED_CMD = 4'hC;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent;
  bit          calm;

  cartridge_bank_mapper_with_scanline_irq dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cartridge_bank_mapper_with_scanline_irq_checker checker_inst (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("cartridge_bank_mapper_with_scanline_irq regression: fail");
    $finish;
  end

  // Stall the result side at random unless in a calm stretch
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 27);
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input op_t op, input logic [15:0] addr, input logic [7:0] data,
                           input logic [8:0] line, input logic rend);
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, rend, line, data, addr};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Write a port, with random bits outside the decode mask
  task automatic write_port(input logic [15:0] port, input logic [7:0] data);
    send_item(OP_WRITE, port | (16'($urandom) & ~ADDR_MASK), data,
              9'($urandom), 1'($urandom));
  endtask

  task automatic tick(input logic [8:0] line, input logic rend);
    send_item(OP_TICK, 16'($urandom), 8'($urandom), line, rend);
  endtask

  function automatic logic [7:0] command_byte(logic flip, logic swap, logic [3:0] idx);
    return {flip, swap, 2'b00, idx};
  endfunction

  initial begin
    int unsigned burst;
    logic [8:0]  line;
    logic [7:0]  latch;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    calm       = 1'b0;
    sent       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tick with interrupt off, then one write of each bank flavor
    tick(9'd0, 1'b1);
    write_port(PORT_CMD, command_byte(1'b1, 1'b0, CMD_CHR_2K_0));
    write_port(PORT_DATA, 8'hFF);
    write_port(PORT_CMD, command_byte(1'b0, 1'b1, CMD_CHR_2K_1));
    write_port(PORT_DATA, 8'h01);
    write_port(PORT_CMD, command_byte(1'b1, 1'b0, CMD_CHR_1K_2));
    write_port(PORT_DATA, 8'h00);
    write_port(PORT_CMD, command_byte(1'b0, 1'b1, CMD_PRG_0));
    write_port(PORT_DATA, 8'h80);
    // 1 KB windows that ignore the invert flag
    write_port(PORT_CMD, command_byte(1'b1, 1'b1, CMD_CHR_1K_8));
    write_port(PORT_DATA, 8'hFF);
    write_port(PORT_CMD, command_byte(1'b1, 1'b0, CMD_CHR_1K_9));
    write_port(PORT_DATA, 8'h00);
    // Unused command index gives nothing
    write_port(PORT_CMD, command_byte(1'b1, 1'b1, UNUSED_CMD));
    write_port(PORT_DATA, 8'hFF);
    write_port(PORT_CMD, command_byte(1'b0, 1'b1, CMD_PRG_2));
    write_port(PORT_DATA, 8'hFF);
    write_port(PORT_MIRROR, 8'h01);
    write_port(PORT_MIRROR, 8'hFE);
    // Undecoded address
    send_item(OP_WRITE, 16'h8002, 8'hFF, 9'h1FF, 1'b1);
    // Interrupt every counted line, with off-screen and blanked ticks between
    write_port(PORT_LATCH, 8'd1);
    write_port(PORT_IRQ_ON, 8'h00);
    tick(LAST_VISIBLE_LINE, 1'b1);
    tick(LAST_VISIBLE_LINE + 9'd1, 1'b1);
    tick(9'd0, 1'b0);
    tick(9'd0, 1'b1);
    write_port(PORT_IRQ_OFF, 8'hFF);
    tick(9'd5, 1'b1);

    // Random: mostly well-formed bank, mirroring and interrupt sequences
    while (sent < 1030) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          write_port(PORT_CMD, 8'($urandom));
          write_port(PORT_DATA, 8'($urandom));
        end
        3: write_port(PORT_MIRROR, 8'($urandom));
        4: begin
          latch = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(6));
          write_port(PORT_LATCH, latch);
          if ($urandom_range(2) == 0) write_port(PORT_RELOAD, 8'($urandom));
          write_port(($urandom_range(4) == 0) ? PORT_IRQ_OFF : PORT_IRQ_ON, 8'($urandom));
        end
        5, 6, 7: begin
          // Run of scanline ticks, mostly in sequence
          burst = $urandom_range(24, 1);
          line  = 9'($urandom_range(261));
          repeat (burst) begin
            tick(($urandom_range(7) == 0) ? 9'($urandom) : line, $urandom_range(9) != 0);
            line++;
          end
        end
        8: send_item(op_t'($urandom_range(1)), 16'($urandom), 8'($urandom),
                     9'($urandom), 1'($urandom));
        default: begin
          // Broken sequences: data port without a command, blanked tick
          if ($urandom_range(1) == 0) write_port(PORT_DATA, 8'($urandom));
          else tick(9'($urandom), 1'b0);
        end
      endcase
    end

    // Reload value zero: wrap through 256 counted lines with no stalls
    calm = 1'b1;
    write_port(PORT_LATCH, 8'd0);
    write_port(PORT_IRQ_ON, 8'($urandom));
    repeat (260) tick(9'($urandom_range(239)), 1'b1);
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then let any stray result show up
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("cartridge_bank_mapper_with_scanline_irq regression: pass");
    end else begin
      $display("cartridge_bank_mapper_with_scanline_irq regression: fail");
    end
    $finish;
  end

endmodule
